FILE: sv/bgc_pkg.sv
`default_nettype none

package bgc_pkg;

  // Width of the tick counter, which advances once per processed beat, and of every timestamp
  localparam int TIME_WIDTH = 32;
  localparam int CFG_WIDTH  = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [CFG_WIDTH-1:0]  cfg_word_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_DOUBLE_CLICK = 2'd1,
    REG_LONG_PRESS   = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    GEST_NONE       = 3'd0,
    GEST_SINGLE     = 3'd1,
    GEST_DOUBLE     = 3'd2,
    GEST_LONG       = 3'd3,
    GEST_LONG_REL   = 3'd4
  } gesture_t;

  typedef struct packed {
    cfg_word_t debounce_ms;
    cfg_word_t double_click_ms;
    cfg_word_t long_press_ms;
  } cfg_t;

  localparam cfg_word_t DEBOUNCE_RESET     = 16'd50;
  localparam cfg_word_t DOUBLE_CLICK_RESET = 16'd300;
  localparam cfg_word_t LONG_PRESS_RESET   = 16'd1000;

  // Zero-extend a configuration value to timestamp width
  function automatic time_t widen(input cfg_word_t v);
    return {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: sv/bgc_core.sv
`default_nettype none

module bgc_core
  import bgc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire logic     raw,
  input  wire cfg_t     cfg,
  output gesture_t      gesture_next
);

  time_t tick_count;
  logic  prev_raw;
  logic  stable_level;
  time_t raw_change_time;
  time_t release_time;
  time_t press_time;
  logic  await_second;
  logic  held_flag;
  logic  long_reported;

  logic  stable_level_next;
  time_t raw_change_time_next;
  time_t release_time_next;
  time_t press_time_next;
  logic  await_second_next;
  logic  held_flag_next;
  logic  long_reported_next;

  time_t now;
  time_t deb_elapsed;
  time_t rel_elapsed;
  time_t press_elapsed;
  time_t rel_elapsed_late;

  assign now = tick_count;

  always_comb begin
    stable_level_next    = stable_level;
    release_time_next    = release_time;
    press_time_next      = press_time;
    await_second_next    = await_second;
    held_flag_next       = held_flag;
    long_reported_next   = long_reported;
    gesture_next         = GEST_NONE;

    raw_change_time_next = (raw != prev_raw) ? now : raw_change_time;
    deb_elapsed          = now - raw_change_time_next;
    rel_elapsed          = now - release_time;

    // Debounced edge
    if ((deb_elapsed > widen(cfg.debounce_ms)) && (raw != stable_level)) begin
      stable_level_next = raw;
      if (!raw) begin
        press_time_next    = now;
        held_flag_next     = 1'b1;
        long_reported_next = 1'b0;
      end else begin
        if (held_flag) begin
          if (long_reported) begin
            gesture_next = GEST_LONG_REL;
          end else if (await_second) begin
            if (rel_elapsed <= widen(cfg.double_click_ms)) begin
              gesture_next      = GEST_DOUBLE;
              await_second_next = 1'b0;
            end
          end else begin
            await_second_next = 1'b1;
            release_time_next = now;
          end
        end
        held_flag_next = 1'b0;
      end
    end

    // Long press
    press_elapsed = now - press_time_next;
    if (held_flag_next && !long_reported_next &&
        (press_elapsed >= widen(cfg.long_press_ms))) begin
      gesture_next       = GEST_LONG;
      long_reported_next = 1'b1;
    end

    // Single-click timeout overrides everything else
    rel_elapsed_late = now - release_time_next;
    if (await_second_next && !held_flag_next &&
        (rel_elapsed_late > widen(cfg.double_click_ms))) begin
      gesture_next      = GEST_SINGLE;
      await_second_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count      <= '0;
      prev_raw        <= 1'b1;
      stable_level    <= 1'b1;
      raw_change_time <= '0;
      release_time    <= '0;
      press_time      <= '0;
      await_second    <= 1'b0;
      held_flag       <= 1'b0;
      long_reported   <= 1'b0;
    end else if (step) begin
      tick_count      <= now + time_t'(1);
      prev_raw        <= raw;
      stable_level    <= stable_level_next;
      raw_change_time <= raw_change_time_next;
      release_time    <= release_time_next;
      press_time      <= press_time_next;
      await_second    <= await_second_next;
      held_flag       <= held_flag_next;
      long_reported   <= long_reported_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/button_gesture_classifier_unit.sv
// Channel   Direction  Handshake             Payload
// ---------------------------------------------------------------
// in        sink       in_valid / in_ready   pin_level [0:0]
// out       source     out_valid / out_ready gesture [2:0]
// cfg       sink       cfg_write             cfg_index [1:0], cfg_data [15:0]
//
// One beat in gives one beat out. Unless out stalls, throughput is one beat
// per cycle: the input register feeds a single pass of subtract/compare
// logic that updates the gesture state and loads the result. Reset (rst,
// synchronous) restores the power-up registers and empties both stages.
// While out stalls, one beat waits in the input register; in_ready drops
// only when both stages are full and out_ready is low.
`default_nettype none

module button_gesture_classifier_unit
  import bgc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       pin_level,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      gesture,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_WIDTH-1:0]       cfg_data
);

  cfg_t     cfg;
  logic     s1_valid;
  logic     s1_pin;
  logic     advance;
  gesture_t gesture_next;
  gesture_t gesture_reg;

  // Configuration registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= DEBOUNCE_RESET;
      cfg.double_click_ms <= DOUBLE_CLICK_RESET;
      cfg.long_press_ms   <= LONG_PRESS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the input stage whenever the result register is free or draining
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Hold the sampled level until the stage advances
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin <= pin_level;
    end
  end

  bgc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .raw          (s1_pin),
    .cfg          (cfg),
    .gesture_next (gesture_next)
  );

  // Result register: load on advance, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_reg <= gesture_next;
    end
  end

  assign gesture = gesture_reg;

  // An accepted beat always lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted beat not held in input stage");

  // Input only stalls when both stages are full and out is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");

  // Every advance produces a result beat in the next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advance did not produce a result");

endmodule

`default_nettype wire

FILE: sim/gesture_checker.sv
`timescale 1ns / 1ps

module gesture_checker
  import bgc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic                       pin_level,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [2:0]                 gesture,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  output int                         mismatches,
  output int                         outstanding,
  output int                         compared,
  output logic [4:0]                 codes_seen
);

  // Shadow copy of the block's registers and gesture state
  cfg_word_t debounce_cfg;
  cfg_word_t window_cfg;
  cfg_word_t hold_cfg;

  time_t clock_ticks;
  logic  last_raw;
  logic  settled;
  time_t raw_edge_at;
  time_t released_at;
  time_t pressed_at;
  logic  waiting_second;
  logic  held;
  logic  long_sent;

  gesture_t expected_gestures[$];
  int       fail_total;
  int       beats_compared;
  logic [4:0] seen;

  function automatic time_t since(input time_t now_t, input time_t then_t);
    return now_t - then_t;
  endfunction

  // Classify one millisecond tick; checks later in the tick override earlier ones
  task automatic classify_tick(input logic level, output gesture_t g);
    time_t now_t;
    now_t = clock_ticks;
    g = GEST_NONE;
    if (level != last_raw)
      raw_edge_at = now_t;
    if (since(now_t, raw_edge_at) > time_t'(debounce_cfg) && level != settled) begin
      settled = level;
      if (!settled) begin
        pressed_at = now_t;
        held = 1'b1;
        long_sent = 1'b0;
      end else begin
        if (held) begin
          if (long_sent) begin
            g = GEST_LONG_REL;
          end else if (waiting_second) begin
            // a second release past the window falls through to the timeout
            if (since(now_t, released_at) <= time_t'(window_cfg)) begin
              g = GEST_DOUBLE;
              waiting_second = 1'b0;
            end
          end else begin
            waiting_second = 1'b1;
            released_at = now_t;
          end
        end
        held = 1'b0;
      end
    end
    if (held && !long_sent && since(now_t, pressed_at) >= time_t'(hold_cfg)) begin
      g = GEST_LONG;
      long_sent = 1'b1;
    end
    if (waiting_second && since(now_t, released_at) > time_t'(window_cfg) && !held) begin
      g = GEST_SINGLE;
      waiting_second = 1'b0;
    end
    last_raw = level;
    clock_ticks = now_t + 1'b1;
  endtask

  always @(posedge clk) begin
    gesture_t want;
    if (rst) begin
      debounce_cfg = DEBOUNCE_RESET;
      window_cfg = DOUBLE_CLICK_RESET;
      hold_cfg = LONG_PRESS_RESET;
      clock_ticks = '0;
      last_raw = 1'b1;
      settled = 1'b1;
      raw_edge_at = '0;
      released_at = '0;
      pressed_at = '0;
      waiting_second = 1'b0;
      held = 1'b0;
      long_sent = 1'b0;
      expected_gestures.delete();
      fail_total = 0;
      beats_compared = 0;
      seen = '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DEBOUNCE:     debounce_cfg = cfg_data;
          REG_DOUBLE_CLICK: window_cfg = cfg_data;
          REG_LONG_PRESS:   hold_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        classify_tick(pin_level, want);
        expected_gestures.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_gestures.size() == 0) begin
          $error("gesture: expected nothing, actual %0d", gesture);
          fail_total++;
        end else begin
          want = expected_gestures.pop_front();
          beats_compared++;
          if (gesture !== want) begin
            $error("gesture: expected %0d, actual %0d", want, gesture);
            fail_total++;
          end
          if (gesture <= GEST_LONG_REL)
            seen[gesture] = 1'b1;
        end
      end
    end
    mismatches <= fail_total;
    outstanding <= expected_gestures.size();
    compared <= beats_compared;
    codes_seen <= seen;
  end

endmodule

FILE: sim/button_gesture_classifier_unit_tb.sv
`timescale 1ns / 1ps

module button_gesture_classifier_unit_tb;
  import bgc_pkg::*;

  // Bound on the whole run; the slowest legal run is far below this
  localparam int CYCLE_LIMIT = 200000;

  // Receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_WINDOWED,
    RX_STARVED
  } rx_mode_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       pin_level;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  logic [2:0]                 gesture;
  logic                       cfg_write;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]       cfg_data;

  int         mismatches;
  int         outstanding;
  int         compared;
  logic [4:0] codes_seen;

  rx_mode_t rx_mode = RX_STEADY;
  logic [3:0] rx_phase = '0;

  // Sender burst bookkeeping
  logic bursty;
  int   burst_left;
  int   ticks_sent;
  int   settings_used;
  int   cycles;

  // Register values currently in the block, kept to shape the stimulus
  int debounce_now;
  int window_now;
  int hold_now;

  button_gesture_classifier_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pin_level (pin_level),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gesture   (gesture),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gesture_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_level   (pin_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .gesture     (gesture),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared),
    .codes_seen  (codes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall according to the pattern chosen for the current phase
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_mode)
      RX_STEADY:   out_ready <= 1'b1;
      RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
      RX_WINDOWED: out_ready <= (rx_phase > 4'd5);
      default:     out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog: give up if the run hangs on a handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d gestures still owed", cycles, outstanding);
      $display("button_gesture_classifier_unit_tb failed");
      $finish;
    end
  end

  // Send one tick beat; in bursty mode, drop valid for a random gap between bursts
  task automatic drive_tick(input logic level);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    pin_level <= level;
    // hold valid and the level until the beat is taken
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0)
      burst_left--;
    ticks_sent++;
  endtask

  // Hold a level for n ticks, optionally preceded by contact bounce
  task automatic hold_level(input logic level, input int n, input logic bounce);
    if (bounce && debounce_now > 0 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        drive_tick(level);
        drive_tick(~level);
      end
    end
    repeat (n) drive_tick(level);
  endtask

  // Drop valid and wait until every predicted gesture has come back
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write all three registers on consecutive cycles while the block is idle
  task automatic set_config(input int deb, input int dbl, input int lp);
    cfg_write <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= cfg_word_t'(deb);
    @(posedge clk);
    cfg_index <= REG_DOUBLE_CLICK;
    cfg_data <= cfg_word_t'(dbl);
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= cfg_word_t'(lp);
    @(posedge clk);
    cfg_write <= 1'b0;
    debounce_now = deb;
    window_now = dbl;
    hold_now = lp;
    settings_used++;
  endtask

  // One random button gesture, with lengths scaled to the current settings
  task automatic play_gesture;
    int d;
    int w;
    int lp;
    int pick;
    d = (debounce_now > 64) ? 64 : debounce_now;
    w = (window_now > 30) ? 30 : window_now;
    lp = (hold_now > 40) ? 40 : hold_now;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      // click; the release gap straddles the double-click window
      hold_level(1'b0, d + 1 + $urandom_range(0, lp), 1'b1);
      hold_level(1'b1, d + 1 + $urandom_range(0, w + d + 3), 1'b1);
    end else if (pick < 14) begin
      // quick click, then a second press held past the window
      hold_level(1'b0, d + 1 + $urandom_range(0, 1), 1'b1);
      hold_level(1'b1, d + 1 + $urandom_range(0, 1), 1'b1);
      hold_level(1'b0, d + 1 + w + $urandom_range(1, 4), 1'b1);
      hold_level(1'b1, d + 2, 1'b1);
    end else if (pick < 17) begin
      // long press and release
      hold_level(1'b0, d + 2 + lp + $urandom_range(0, 4), 1'b1);
      hold_level(1'b1, d + 1 + $urandom_range(0, w), 1'b1);
    end else begin
      // raw noise
      repeat ($urandom_range(1, 10)) drive_tick(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int deb, input int dbl, input int lp, input int budget,
                           input logic sender_gaps, input rx_mode_t rx);
    int stop_at;
    drain;
    set_config(deb, dbl, lp);
    bursty = sender_gaps;
    burst_left = 0;
    rx_mode <= rx;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at)
      play_gesture;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    pin_level <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= '0;
    ticks_sent = 0;
    settings_used = 0;
    bursty = 1'b0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: no debounce delay, short windows; click, double click at the
    // window edge, long press with its release, then a click that times out
    set_config(0, 4, 4);
    bursty = 1'b1;
    rx_mode <= RX_RANDOM;
    hold_level(1'b0, 3, 1'b0);
    hold_level(1'b1, 2, 1'b0);
    hold_level(1'b0, 2, 1'b0);
    hold_level(1'b1, 2, 1'b0);
    hold_level(1'b0, 6, 1'b0);
    hold_level(1'b1, 2, 1'b0);
    hold_level(1'b0, 2, 1'b0);
    hold_level(1'b1, 7, 1'b0);

    // Random phases across low extremes, high extremes and mixed settings
    run_phase(0, 0, 0, 90, 1'b1, RX_RANDOM);
    run_phase(1, 6, 12, 100, 1'b0, RX_STEADY);
    run_phase($urandom_range(0, 4), $urandom_range(2, 25), $urandom_range(4, 40), 100,
              1'b1, RX_WINDOWED);
    run_phase(65535, 65535, 65535, 50, 1'b1, RX_STARVED);
    run_phase(2, 65535, 20, 70, 1'b0, RX_RANDOM);
    run_phase($urandom_range(0, 4), $urandom_range(2, 25), $urandom_range(4, 40), 90,
              1'b1, RX_WINDOWED);
    run_phase(3, 10, 65535, 60, 1'b1, RX_STEADY);

    drain;
    repeat (10) @(posedge clk);

    $display("Sent %0d ticks under %0d register settings; %0d gestures compared",
             ticks_sent, settings_used, compared);
    $display("Gesture codes seen (bit per code, long release down to none): %b", codes_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("button_gesture_classifier_unit_tb passed");
    end else begin
      $display("button_gesture_classifier_unit_tb failed");
    end
    $finish;
  end

endmodule
